### hw/rtl/smm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg
// Types and constants shared by the set mean and median block.
// ----------------------------------------------------------------------------
package smm_pkg;

	localparam int VALUE_W       = 16;
	localparam int MEDIAN_W      = 17;
	localparam int MEAN_W        = 24;
	localparam int COUNT_W       = 7;
	localparam int FRAC_W        = 8;
	localparam int MAX_ITEMS_DEF = 64;
	localparam int QUEUE_DEF     = 4;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} in_t;

	typedef struct packed {
		logic [MEDIAN_W-1:0] median_x2;
		logic [MEAN_W-1:0]   mean_q8;
		logic [COUNT_W-1:0]  count;
		logic                overflow;
	} out_t;

	// classified item between front and back
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               keep;
	} q_item_t;

	// sorter control from the back controller
	typedef struct packed {
		logic               ins;
		logic               shl;
		logic               clr;
		logic [VALUE_W-1:0] value;
	} sort_ctl_t;

endpackage

### hw/rtl/smm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_front
// Accepts items, counts the current set and marks values past capacity.
// ----------------------------------------------------------------------------
module smm_front #(
	parameter int MAX_ITEMS = smm_pkg::MAX_ITEMS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  smm_pkg::in_t    item,
	input  logic            full,
	output logic            busy,
	output logic            push,
	output smm_pkg::q_item_t push_data
);

	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [CW-1:0] cnt_q;
	logic          keep;

	assign busy = full;
	assign push = start && !full;
	assign keep = cnt_q != CW'(MAX_ITEMS);

	assign push_data.value = item.value;
	assign push_data.last  = item.last;
	assign push_data.keep  = keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (item.last) begin
				cnt_q <= '0;
			end else if (keep) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

endmodule

### hw/rtl/smm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_fifo
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module smm_fifo #(
	parameter int DEPTH = smm_pkg::QUEUE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  smm_pkg::q_item_t push_data,
	output logic             full,
	input  logic             pop,
	output smm_pkg::q_item_t pop_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	smm_pkg::q_item_t mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [LW-1:0]    lvl_q;

	assign full     = lvl_q == LW'(DEPTH);
	assign empty    = lvl_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			lvl_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				lvl_q <= lvl_q + LW'(1);
			end else if (pop && !push) begin
				lvl_q <= lvl_q - LW'(1);
			end
		end
	end

endmodule

### hw/rtl/smm_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_sorter
// Row of insertion cells kept in ascending order, one insert per cycle.
// A left shift walks the middle values to the two head taps.
// ----------------------------------------------------------------------------
module smm_sorter #(
	parameter int N = smm_pkg::MAX_ITEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  smm_pkg::sort_ctl_t          ctl,
	output logic [smm_pkg::VALUE_W-1:0] tap0,
	output logic [smm_pkg::VALUE_W-1:0] tap1
);

	localparam int W = smm_pkg::VALUE_W;

	logic [W-1:0] cell_q [N];
	logic [N-1:0] vld_q;
	logic [N-1:0] big;
	logic [N-1:0] prev_big;
	logic [N-1:0] prev_vld;
	logic [W-1:0] prev_val [N];
	logic [W-1:0] next_val [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		// empty cells count as larger than any value
		assign big[i] = !vld_q[i] || (cell_q[i] > ctl.value);

		if (i == 0) begin : g_head
			assign prev_big[i] = 1'b0;
			assign prev_vld[i] = 1'b1;
			assign prev_val[i] = ctl.value;
		end else begin : g_body
			assign prev_big[i] = big[i-1];
			assign prev_vld[i] = vld_q[i-1];
			assign prev_val[i] = cell_q[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign next_val[i] = cell_q[i];
		end else begin : g_mid
			assign next_val[i] = cell_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (ctl.ins && big[i]) begin
				cell_q[i] <= prev_big[i] ? prev_val[i] : ctl.value;
			end else if (ctl.shl) begin
				cell_q[i] <= next_val[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (ctl.clr) begin
				vld_q[i] <= 1'b0;
			end else if (ctl.ins) begin
				vld_q[i] <= vld_q[i] | prev_vld[i];
			end
		end
	end

	assign tap0 = cell_q[0];

	if (N > 1) begin : g_tap1
		assign tap1 = cell_q[1];
	end else begin : g_tap1_single
		assign tap1 = cell_q[0];
	end

endmodule

### hw/rtl/smm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smm_div #(
	parameter int DW = 31,
	parameter int NW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic          running,
	output logic [DW-1:0] quotient
);

	localparam int SCW = $clog2(DW + 1);

	logic [SCW-1:0] step_q;
	logic [NW-1:0]  rem_q;
	logic [NW-1:0]  den_q;
	logic [DW-1:0]  quo_q;
	logic [NW:0]    trial;
	logic [NW:0]    diff;
	logic           ge;

	assign trial    = {rem_q, quo_q[DW-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign diff     = trial - {1'b0, den_q};
	assign running  = step_q != '0;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (running) begin
			rem_q <= ge ? diff[NW-1:0] : trial[NW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= SCW'(DW);
		end else if (running) begin
			step_q <= step_q - SCW'(1);
		end
	end

endmodule

### hw/rtl/smm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_back
// Drains the queue into the sorter, keeps sum and count, and on the last
// value of a set finds the median and the mean and emits the result.
// ----------------------------------------------------------------------------
module smm_back #(
	parameter int MAX_ITEMS = smm_pkg::MAX_ITEMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  smm_pkg::q_item_t pop_data,
	output logic             pop,
	output logic             done,
	output smm_pkg::out_t    result
);

	localparam int VW = smm_pkg::VALUE_W;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int SW = VW + CW;
	localparam int DW = SW + smm_pkg::FRAC_W;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_FIN  = 2'b10
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_nx;
	logic [CW-1:0]      shift_q;
	logic [SW-1:0]      sum_q;
	logic [SW-1:0]      sum_nx;
	logic               drop_q;
	logic               div_start;
	logic               div_running;
	logic [DW-1:0]      quotient;
	logic [VW-1:0]      tap0;
	logic [VW-1:0]      tap1;
	logic               fin_done;
	logic [smm_pkg::MEDIAN_W-1:0] median;
	smm_pkg::sort_ctl_t ctl;
	smm_pkg::out_t      res_q;
	logic               done_q;

	assign pop       = (state_q == ST_LOAD) && !empty;
	assign cnt_nx    = cnt_q + CW'(pop_data.keep);
	assign sum_nx    = sum_q + (pop_data.keep ? SW'(pop_data.value) : '0);
	assign div_start = pop && pop_data.last;
	assign fin_done  = (state_q == ST_FIN) && !div_running && (shift_q == '0);

	assign ctl.ins   = pop && pop_data.keep;
	assign ctl.shl   = (state_q == ST_FIN) && (shift_q != '0);
	assign ctl.clr   = fin_done;
	assign ctl.value = pop_data.value;

	// odd count: twice the middle value, even: sum of the middle pair
	assign median = cnt_q[0] ? {tap0, 1'b0}
	                         : smm_pkg::MEDIAN_W'(tap0) + smm_pkg::MEDIAN_W'(tap1);

	smm_sorter #(
		.N (MAX_ITEMS)
	) u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.tap0   (tap0),
		.tap1   (tap1)
	);

	smm_div #(
		.DW (DW),
		.NW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_nx, smm_pkg::FRAC_W'(0)}),
		.divisor  (cnt_nx),
		.running  (div_running),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
			shift_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (pop) begin
						cnt_q <= cnt_nx;
						sum_q <= sum_nx;
						if (!pop_data.keep) begin
							drop_q <= 1'b1;
						end
						if (pop_data.last) begin
							shift_q <= (cnt_nx - CW'(1)) >> 1;
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (shift_q != '0) begin
						shift_q <= shift_q - CW'(1);
					end
					if (fin_done) begin
						done_q  <= 1'b1;
						cnt_q   <= '0;
						sum_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fin_done) begin
			res_q.median_x2 <= median;
			res_q.mean_q8   <= smm_pkg::MEAN_W'(quotient);
			res_q.count     <= smm_pkg::COUNT_W'(cnt_q);
			res_q.overflow  <= drop_q;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

### hw/rtl/set_mean_and_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_mean_and_median
// Median and mean of a set of unsigned 16-bit values.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low; busy is high
// only while the input queue (QUEUE_DEPTH entries) is full. While a set loads,
// the sorter row takes one queued value per cycle, so items may be sent every
// cycle. After the last value of a set leaves the queue the back end runs the
// restoring divider and the median shift, then shows the result for exactly
// one cycle with done high; the receiver cannot stall it. Items of the next
// set are queued meanwhile. Values beyond MAX_ITEMS in one set are dropped
// and flagged.
// ----------------------------------------------------------------------------
module set_mean_and_median #(
	parameter int MAX_ITEMS   = smm_pkg::MAX_ITEMS_DEF,
	parameter int QUEUE_DEPTH = smm_pkg::QUEUE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  smm_pkg::in_t  item,
	output logic          done,
	output smm_pkg::out_t result
);

	logic             push;
	logic             full;
	logic             pop;
	logic             empty;
	smm_pkg::q_item_t push_data;
	smm_pkg::q_item_t pop_data;

	smm_front #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.full      (full),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	smm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	smm_back #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop_data (pop_data),
		.pop      (pop),
		.done     (done),
		.result   (result)
	);

endmodule
